// ===== sv/clis_pkg.sv =====
`default_nettype none

package clis_pkg;

	// Width of an input value and of a subsequence count.
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 32;

	// Largest count; a sum that reaches it is held there and flagged.
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Per-cell control from the top level: where the cell sits relative to
	// the current fill level of the chain.
	typedef struct packed {
		logic occupied; // the cell holds an earlier element
		logic tail;     // the cell is the first free one and takes the word
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/count_longest_increasing_subsequences_core.sv =====
`default_nettype none

// Channel   Dir  Word contents (lowest bit first)
// s_axis    in   tdata: value[31:0]; tlast: last element of the sequence
// m_axis    out  tdata: count[31:0], best_length, zero fill; tuser: saturated, too_long
//
// A stored element walks the full chain of cells, one cell per cycle, and its
// result is then folded into the running pair; only after that can the next
// word be taken. An element beyond capacity is dropped without a walk; one
// that carries tlast also passes through ST_FIN to complete the sequence.
// Reset clears the control state and the running pair at once; cell contents
// need no clearing since only cells below the fill level are ever compared.
// A pending result waits in the output register while the next word is taken;
// only the completion of a following sequence stalls until it is taken.

module count_longest_increasing_subsequences_core #(
	parameter int unsigned MAX_ITEMS = 64,
	localparam int unsigned LEN_W    = $clog2(MAX_ITEMS + 1),
	localparam int unsigned OUT_W    = ((clis_pkg::COUNT_W + LEN_W + 7) / 8) * 8
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire  [clis_pkg::VALUE_W-1:0]  s_axis_tdata,  // value
	input  wire                           s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	output logic [OUT_W-1:0]              m_axis_tdata,  // count, best_length, zero fill
	output logic [1:0]                    m_axis_tuser   // saturated, too_long
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_FIN
	} state_t;

	state_t                        state_q;
	logic [LEN_W-1:0]              item_cnt_q;   // number of stored elements
	logic [LEN_W-1:0]              gl_len_q;     // running best length
	logic [clis_pkg::COUNT_W-1:0]  gl_cnt_q;     // subsequences of that length
	logic                          sat_q;
	logic                          drop_q;
	logic                          last_q;       // the word in flight ends the sequence
	logic                          upd_q;        // the word in flight was stored
	logic [LEN_W-1:0]              p_len_q;      // result of the chain walk
	logic [clis_pkg::COUNT_W-1:0]  p_cnt_q;
	logic                          p_sat_q;
	logic                          out_vld_q;
	logic [clis_pkg::COUNT_W-1:0]  out_cnt_q;
	logic [LEN_W-1:0]              out_len_q;
	logic                          out_sat_q;
	logic                          out_drop_q;

	// The chain: index 0 is the entry, index MAX_ITEMS the exit.
	logic                          tok_vld [0:MAX_ITEMS];
	logic [clis_pkg::VALUE_W-1:0]  tok_val [0:MAX_ITEMS];
	logic [LEN_W-1:0]              tok_len [0:MAX_ITEMS];
	logic [clis_pkg::COUNT_W-1:0]  tok_cnt [0:MAX_ITEMS];
	logic                          tok_sat [0:MAX_ITEMS];

	logic                          in_acc;
	logic                          room;
	logic                          upd;
	logic                          out_free;
	logic                          emit;
	logic [clis_pkg::COUNT_W:0]    g_sum;
	logic [LEN_W-1:0]              new_len;
	logic [clis_pkg::COUNT_W-1:0]  new_cnt;
	logic                          new_sat;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign room          = (item_cnt_q < LEN_W'(MAX_ITEMS));
	assign out_free      = !out_vld_q || m_axis_tready;
	// The sequence result is loaded into the output register in this cycle.
	assign emit          = (state_q == ST_FIN) && last_q && out_free;

	// A new element enters the chain as a word of length one and count one.
	assign tok_vld[0] = in_acc && room;
	assign tok_val[0] = s_axis_tdata;
	assign tok_len[0] = LEN_W'(1);
	assign tok_cnt[0] = clis_pkg::COUNT_W'(1);
	assign tok_sat[0] = 1'b0;

	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		clis_pkg::cell_ctrl_t ctrl;

		// Cells below the fill level hold earlier elements; the cell at the
		// fill level stores the word as it passes.
		assign ctrl.occupied = (LEN_W'(k) < item_cnt_q);
		assign ctrl.tail     = (LEN_W'(k) == item_cnt_q);

		clis_cell #(
			.LEN_W(LEN_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.tok_in_vld  (tok_vld[k]),
			.tok_in_val  (tok_val[k]),
			.tok_in_len  (tok_len[k]),
			.tok_in_cnt  (tok_cnt[k]),
			.tok_in_sat  (tok_sat[k]),
			.tok_out_vld (tok_vld[k+1]),
			.tok_out_val (tok_val[k+1]),
			.tok_out_len (tok_len[k+1]),
			.tok_out_cnt (tok_cnt[k+1]),
			.tok_out_sat (tok_sat[k+1])
		);
	end

	// Fold the finished element into the running pair. The first element of
	// a sequence is already covered by the reset value of the pair.
	always_comb begin
		upd     = upd_q && (item_cnt_q != '0);
		g_sum   = {1'b0, gl_cnt_q} + {1'b0, p_cnt_q};
		new_len = gl_len_q;
		new_cnt = gl_cnt_q;
		new_sat = sat_q || (upd_q && p_sat_q);
		if (upd) begin
			if (p_len_q == gl_len_q) begin
				if (g_sum[clis_pkg::COUNT_W]) begin
					new_cnt = clis_pkg::COUNT_MAX;
					new_sat = 1'b1;
				end else begin
					new_cnt = g_sum[clis_pkg::COUNT_W-1:0];
					if (g_sum[clis_pkg::COUNT_W-1:0] == clis_pkg::COUNT_MAX) begin
						new_sat = 1'b1;
					end
				end
			end else if (p_len_q > gl_len_q) begin
				new_len = p_len_q;
				new_cnt = p_cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			item_cnt_q <= '0;
			gl_len_q   <= LEN_W'(1);
			gl_cnt_q   <= clis_pkg::COUNT_W'(1);
			sat_q      <= 1'b0;
			drop_q     <= 1'b0;
			last_q     <= 1'b0;
			upd_q      <= 1'b0;
			p_len_q    <= '0;
			p_cnt_q    <= '0;
			p_sat_q    <= 1'b0;
			out_vld_q  <= 1'b0;
			out_cnt_q  <= '0;
			out_len_q  <= '0;
			out_sat_q  <= 1'b0;
			out_drop_q <= 1'b0;
		end else begin
			out_vld_q <= emit || (out_vld_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= s_axis_tlast;
						upd_q  <= room;
						if (room) begin
							state_q <= ST_BUSY;
						end else begin
							// Full: the element is dropped and only flagged.
							drop_q <= 1'b1;
							if (s_axis_tlast) begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_BUSY: begin
					if (tok_vld[MAX_ITEMS]) begin
						p_len_q <= tok_len[MAX_ITEMS];
						p_cnt_q <= tok_cnt[MAX_ITEMS];
						p_sat_q <= tok_sat[MAX_ITEMS];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						gl_len_q   <= new_len;
						gl_cnt_q   <= new_cnt;
						sat_q      <= new_sat;
						item_cnt_q <= item_cnt_q + LEN_W'(upd_q);
						state_q    <= ST_IDLE;
					end else if (out_free) begin
						// End of sequence: emit and return to the cleared state.
						out_cnt_q  <= new_cnt;
						out_len_q  <= new_len;
						out_sat_q  <= new_sat;
						out_drop_q <= drop_q;
						item_cnt_q <= '0;
						gl_len_q   <= LEN_W'(1);
						gl_cnt_q   <= clis_pkg::COUNT_W'(1);
						sat_q      <= 1'b0;
						drop_q     <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'({out_len_q, out_cnt_q});
	assign m_axis_tuser  = {out_drop_q, out_sat_q};

	// A word leaves the chain only while the controller waits for it.
	a_exit_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok_vld[MAX_ITEMS] |-> (state_q == ST_BUSY))
		else $error("chain word emerged outside of a walk");

	// The fill level never passes the number of cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= LEN_W'(MAX_ITEMS))
		else $error("fill level beyond capacity");

	// A finished sequence holds while an earlier result is still pending.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && last_q && m_axis_tvalid && !m_axis_tready)
		|=> (state_q == ST_FIN && $stable(m_axis_tdata)))
		else $error("pending result overwritten");

	// The running best length is never zero.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gl_len_q != '0)
		else $error("running best length is zero");

endmodule

`default_nettype wire

// ===== sv/clis_cell.sv =====
`default_nettype none

module clis_cell #(
	parameter int unsigned LEN_W = 7
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire clis_pkg::cell_ctrl_t        ctrl,
	input  wire                              tok_in_vld,
	input  wire  [clis_pkg::VALUE_W-1:0]     tok_in_val,
	input  wire  [LEN_W-1:0]                 tok_in_len,
	input  wire  [clis_pkg::COUNT_W-1:0]     tok_in_cnt,
	input  wire                              tok_in_sat,
	output logic                             tok_out_vld,
	output logic [clis_pkg::VALUE_W-1:0]     tok_out_val,
	output logic [LEN_W-1:0]                 tok_out_len,
	output logic [clis_pkg::COUNT_W-1:0]     tok_out_cnt,
	output logic                             tok_out_sat
);

	logic [clis_pkg::VALUE_W-1:0] val_q;
	logic [LEN_W-1:0]             len_q;
	logic [clis_pkg::COUNT_W-1:0] cnt_q;

	logic [LEN_W-1:0]             cand;
	logic [clis_pkg::COUNT_W:0]   sum;
	logic                         smaller;
	logic [LEN_W-1:0]             nxt_len;
	logic [clis_pkg::COUNT_W-1:0] nxt_cnt;
	logic                         nxt_sat;

	// The passing word is updated only by an occupied cell whose element is
	// strictly smaller than the incoming one.
	always_comb begin
		cand    = len_q + LEN_W'(1);
		sum     = {1'b0, tok_in_cnt} + {1'b0, cnt_q};
		smaller = ctrl.occupied && ($signed(val_q) < $signed(tok_in_val));
		nxt_len = tok_in_len;
		nxt_cnt = tok_in_cnt;
		nxt_sat = tok_in_sat;
		if (smaller) begin
			if (cand == tok_in_len) begin
				if (sum[clis_pkg::COUNT_W]) begin
					nxt_cnt = clis_pkg::COUNT_MAX;
					nxt_sat = 1'b1;
				end else begin
					nxt_cnt = sum[clis_pkg::COUNT_W-1:0];
					if (sum[clis_pkg::COUNT_W-1:0] == clis_pkg::COUNT_MAX) begin
						nxt_sat = 1'b1;
					end
				end
			end else if (cand > tok_in_len) begin
				nxt_len = cand;
				nxt_cnt = cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_vld <= 1'b0;
		end else begin
			tok_out_vld <= tok_in_vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_out_val <= tok_in_val;
		tok_out_len <= nxt_len;
		tok_out_cnt <= nxt_cnt;
		tok_out_sat <= nxt_sat;
		// All earlier cells have been passed, so the word is final here.
		if (tok_in_vld && ctrl.tail) begin
			val_q <= tok_in_val;
			len_q <= tok_in_len;
			cnt_q <= tok_in_cnt;
		end
	end

endmodule

`default_nettype wire
